// ===== hdl/vtsc_pkg.sv =====
// Shared types, constants and codes for the vision target steering classifier.
`default_nettype none

package vtsc_pkg;

    localparam int FRAME_WIDTH_DEFAULT = 320;
    localparam int REPORT_BYTES        = 15;
    localparam int HEAD_BYTES          = REPORT_BYTES - 1;
    localparam int BYTE_IDX_W          = $clog2(REPORT_BYTES);
    localparam int ROTATE_EXTRA        = 30;
    localparam int QUEUE_DEPTH         = 2;
    // Signed width for the centre band bounds; covers the full frame width range.
    localparam int CMP_W               = 18;

    localparam logic [7:0]  CENTER_MARGIN_RESET = 8'd40;
    localparam logic [23:0] NEAR_AREA_RESET     = 24'd15000;
    localparam logic [23:0] MIN_AREA_RESET      = 24'd150;
    localparam logic [23:0] MAX_AREA_RESET      = 24'd30000;

    typedef enum logic [3:0] {
        STEER_STOP         = 4'd0,
        STEER_STRAIGHT     = 4'd1,
        STEER_ROTATE_LEFT  = 4'd2,
        STEER_ROTATE_RIGHT = 4'd3,
        STEER_LEFT         = 4'd4,
        STEER_RIGHT        = 4'd5,
        STEER_SEEK_LEFT    = 4'd6,
        STEER_SEEK_RIGHT   = 4'd7,
        STEER_SEEK         = 4'd8
    } steer_code_t;

    typedef enum logic [7:0] {
        REG_CENTER_MARGIN = 8'd0,
        REG_NEAR_AREA     = 8'd1,
        REG_MIN_AREA      = 8'd2,
        REG_MAX_AREA      = 8'd3
    } cfg_reg_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       report_start;
    } in_item_t;

    typedef struct packed {
        logic [3:0]  steer_code;
        logic [15:0] blob_x;
        logic [15:0] blob_y;
        logic [15:0] blob_w;
        logic [15:0] blob_h;
        logic [15:0] blob_cx;
        logic [15:0] blob_cy;
        logic [23:0] blob_area;
    } out_item_t;

    // One assembled report, fields decoded, waiting for classification.
    typedef struct packed {
        logic [15:0] blob_x;
        logic [15:0] blob_y;
        logic [15:0] blob_w;
        logic [15:0] blob_h;
        logic [15:0] blob_cx;
        logic [15:0] blob_cy;
        logic [23:0] blob_area;
    } report_t;

    typedef struct packed {
        logic [7:0]  center_margin;
        logic [23:0] near_area;
        logic [23:0] min_area;
        logic [23:0] max_area;
    } cfg_t;

    typedef struct packed {
        logic push;
        logic full;
    } push_ctl_t;

endpackage

`default_nettype wire

// ===== hdl/vtsc_front.sv =====
// Front end: assembles report bytes and hands completed reports to the queue.
`default_nettype none

module vtsc_front
    import vtsc_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      item_valid,
    output logic           item_ready,
    input  wire in_item_t  item,
    input  wire logic      queue_full,
    output push_ctl_t      push_ctl,
    output report_t        push_data
);

    logic [BYTE_IDX_W-1:0] byte_index_reg;
    logic [BYTE_IDX_W-1:0] byte_index_next;
    logic [7:0]            bytes_reg [HEAD_BYTES];
    logic [BYTE_IDX_W-1:0] pos;
    logic                  is_last;
    logic                  accept;

    assign pos     = item.report_start ? '0 : byte_index_reg;
    assign is_last = (pos == BYTE_IDX_W'(HEAD_BYTES));
    // Only the closing byte needs room in the queue.
    assign item_ready = !is_last || !queue_full;
    assign accept     = item_valid && item_ready;

    always_comb
    begin
        byte_index_next = byte_index_reg;
        if (accept)
        begin
            byte_index_next = is_last ? '0 : pos + BYTE_IDX_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_index_reg <= '0;
        end
        else
        begin
            byte_index_reg <= byte_index_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < HEAD_BYTES; i++)
        begin
            if (accept && !is_last && pos == BYTE_IDX_W'(i))
            begin
                bytes_reg[i] <= item.data_byte;
            end
        end
    end

    assign push_ctl.push = accept && is_last;
    assign push_ctl.full = queue_full;

    assign push_data.blob_x    = {bytes_reg[0], bytes_reg[1]};
    assign push_data.blob_y    = {bytes_reg[2], bytes_reg[3]};
    assign push_data.blob_w    = {bytes_reg[4], bytes_reg[5]};
    assign push_data.blob_h    = {bytes_reg[6], bytes_reg[7]};
    assign push_data.blob_cx   = {bytes_reg[8], bytes_reg[9]};
    assign push_data.blob_cy   = {bytes_reg[10], bytes_reg[11]};
    assign push_data.blob_area = {bytes_reg[12], bytes_reg[13], item.data_byte};

endmodule

`default_nettype wire

// ===== hdl/vtsc_queue.sv =====
// Short queue of assembled reports between the front and the back end.
`default_nettype none

module vtsc_queue
    import vtsc_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire push_ctl_t push_ctl,
    input  wire report_t   push_data,
    output logic           full,
    output logic           not_empty,
    input  wire logic      pop,
    output report_t        head
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    report_t            slots_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic               do_push;
    logic               do_pop;

    assign full      = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign do_push   = push_ctl.push && !full;
    assign do_pop    = pop && not_empty;
    assign head      = slots_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slots_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/vtsc_back.sv =====
// Back end: classifies queued reports into steering codes and holds the result.
`default_nettype none

module vtsc_back
    import vtsc_pkg::*;
#(
    parameter int FRAME_WIDTH = FRAME_WIDTH_DEFAULT
)
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire cfg_t    cfg,
    input  wire logic    queue_not_empty,
    input  wire report_t head,
    output logic         pop,
    output logic         result_valid,
    input  wire logic    result_ready,
    output out_item_t    result
);

    localparam int HALF = FRAME_WIDTH / 2;

    logic                     result_valid_reg;
    logic                     result_valid_next;
    out_item_t                result_reg;
    steer_code_t              prev_code_reg;
    logic [15:0]              prev_center_reg;
    steer_code_t              code;
    steer_code_t              seek;
    logic                     seeking;
    logic                     blob_ok;
    logic signed [CMP_W-1:0]  cx_s;
    logic signed [CMP_W-1:0]  lo;
    logic signed [CMP_W-1:0]  hi;
    logic [16:0]              prev_ext;

    assign pop = queue_not_empty && (!result_valid_reg || result_ready);

    assign cx_s     = $signed(CMP_W'(head.blob_cx));
    assign lo       = $signed(CMP_W'(HALF)) - $signed(CMP_W'(cfg.center_margin));
    assign hi       = $signed(CMP_W'(HALF)) + $signed(CMP_W'(cfg.center_margin));
    assign prev_ext = {1'b0, prev_center_reg};
    assign seeking  = (prev_code_reg == STEER_SEEK_LEFT) || (prev_code_reg == STEER_SEEK_RIGHT);

    assign blob_ok = (head.blob_cx != '0)
                  && ({1'b0, head.blob_cx} < 17'(FRAME_WIDTH))
                  && (head.blob_area > cfg.min_area)
                  && (head.blob_area < cfg.max_area);

    always_comb
    begin
        if (!seeking && prev_ext > 17'(HALF) && prev_ext <= 17'(FRAME_WIDTH))
        begin
            seek = STEER_SEEK_RIGHT;
        end
        else if (!seeking && prev_ext < 17'(HALF) && prev_ext != '0)
        begin
            seek = STEER_SEEK_LEFT;
        end
        else if (prev_code_reg == STEER_SEEK_LEFT)
        begin
            seek = STEER_SEEK_LEFT;
        end
        else if (prev_code_reg == STEER_SEEK_RIGHT)
        begin
            seek = STEER_SEEK_RIGHT;
        end
        else
        begin
            seek = STEER_SEEK;
        end
    end

    always_comb
    begin
        if (!blob_ok)
        begin
            code = seek;
        end
        else if (head.blob_area > cfg.near_area)
        begin
            code = STEER_STOP;
        end
        else if (cx_s > lo && cx_s < hi)
        begin
            code = STEER_STRAIGHT;
        end
        else if (cx_s <= lo - $signed(CMP_W'(ROTATE_EXTRA)))
        begin
            code = STEER_ROTATE_LEFT;
        end
        else if (cx_s >= hi + $signed(CMP_W'(ROTATE_EXTRA)))
        begin
            code = STEER_ROTATE_RIGHT;
        end
        else if (cx_s <= lo)
        begin
            code = STEER_LEFT;
        end
        else
        begin
            code = STEER_RIGHT;
        end
    end

    always_comb
    begin
        result_valid_next = result_valid_reg;
        if (pop)
        begin
            result_valid_next = 1'b1;
        end
        else if (result_ready)
        begin
            result_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
            prev_code_reg    <= STEER_SEEK_LEFT;
            prev_center_reg  <= '0;
        end
        else
        begin
            result_valid_reg <= result_valid_next;
            if (pop)
            begin
                prev_code_reg   <= code;
                prev_center_reg <= head.blob_cx;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            result_reg.steer_code <= code;
            result_reg.blob_x     <= head.blob_x;
            result_reg.blob_y     <= head.blob_y;
            result_reg.blob_w     <= head.blob_w;
            result_reg.blob_h     <= head.blob_h;
            result_reg.blob_cx    <= head.blob_cx;
            result_reg.blob_cy    <= head.blob_cy;
            result_reg.blob_area  <= head.blob_area;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

`default_nettype wire

// ===== hdl/vision_target_steering_classifier.sv =====
// Top level of the vision target steering classifier.
//
// Report bytes enter on the item channel (valid/ready), one byte per transfer,
// fifteen to a report, big-endian. A byte with report_start set restarts
// assembly at the first position. Each completed report gives one transfer on
// the result channel carrying the steering code and the decoded blob fields;
// other bytes give nothing.
// Throughput is one byte per cycle while item_ready stays high. The closing
// byte's report is written into the two-entry queue, and the classifier then
// loads its output register from the queue head once that register is free.
// When the receiver stalls, the output register and then the queue fill; only
// a report's closing byte is then held off (item_ready low), all other bytes
// are still taken. A report takes fifteen transfers, so the queue rarely fills.
// Configuration writes (cfg channel, always ready) set the centre margin and
// the three area limits; unknown indexes are ignored. They should be made
// while the block is idle.
// Reset clears the byte position, the queue, the output valid flag, and the
// previous centre and code (seek left); configuration returns to defaults.
`default_nettype none

module vision_target_steering_classifier
    import vtsc_pkg::*;
#(
    parameter int FRAME_WIDTH = FRAME_WIDTH_DEFAULT
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       item_valid,
    output logic            item_ready,
    input  wire in_item_t   item,
    output logic            result_valid,
    input  wire logic       result_ready,
    output out_item_t       result,
    input  wire logic       cfg_valid,
    output logic            cfg_ready,
    input  wire logic [7:0] cfg_index,
    input  wire logic [23:0] cfg_data
);

    cfg_t      cfg_reg;
    push_ctl_t push_ctl;
    report_t   push_data;
    report_t   head;
    logic      queue_full;
    logic      queue_not_empty;
    logic      pop;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.center_margin <= CENTER_MARGIN_RESET;
            cfg_reg.near_area     <= NEAR_AREA_RESET;
            cfg_reg.min_area      <= MIN_AREA_RESET;
            cfg_reg.max_area      <= MAX_AREA_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_CENTER_MARGIN: cfg_reg.center_margin <= cfg_data[7:0];
                REG_NEAR_AREA:     cfg_reg.near_area     <= cfg_data;
                REG_MIN_AREA:      cfg_reg.min_area      <= cfg_data;
                REG_MAX_AREA:      cfg_reg.max_area      <= cfg_data;
                default:           ;
            endcase
        end
    end

    vtsc_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .queue_full (queue_full),
        .push_ctl   (push_ctl),
        .push_data  (push_data)
    );

    vtsc_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push_ctl  (push_ctl),
        .push_data (push_data),
        .full      (queue_full),
        .not_empty (queue_not_empty),
        .pop       (pop),
        .head      (head)
    );

    vtsc_back #(
        .FRAME_WIDTH (FRAME_WIDTH)
    ) u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg             (cfg_reg),
        .queue_not_empty (queue_not_empty),
        .head            (head),
        .pop             (pop),
        .result_valid    (result_valid),
        .result_ready    (result_ready),
        .result          (result)
    );

endmodule

`default_nettype wire

// ===== hdl/vtsc_checker.sv =====
// Port-level checks for the steering classifier, bound to the top level.
`default_nettype none

module vtsc_checker
    import vtsc_pkg::*;
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        item_valid,
    input wire logic        item_ready,
    input wire in_item_t    item,
    input wire logic        result_valid,
    input wire logic        result_ready,
    input wire out_item_t   result,
    input wire logic        cfg_valid,
    input wire logic        cfg_ready,
    input wire logic [7:0]  cfg_index,
    input wire logic [23:0] cfg_data
);

    // A stalled result keeps its payload until the transfer.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result))
    else $error("result changed while stalled");

    // Only a report's closing byte is ever held off, never a start byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        !item_ready |-> !item.report_start)
    else $error("item_ready low outside a closing byte");

    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> result.steer_code <= STEER_SEEK)
    else $error("steering code out of range");

    // Every non-seek code comes from a valid blob, which has a nonzero centre and area.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.steer_code < STEER_SEEK_LEFT
            |-> result.blob_cx != '0 && result.blob_area != '0)
    else $error("valid-blob code on a blob that cannot be valid");

endmodule

bind vision_target_steering_classifier vtsc_checker u_vtsc_checker (.*);

`default_nettype wire

// ===== sim/vision_target_steering_classifier_tb.sv =====
// Testbench for the steering classifier: random blob reports checked against a scoreboard.
`timescale 1ns / 100ps

module vision_target_steering_classifier_tb;
    import vtsc_pkg::*;

    localparam int FRAME_W = FRAME_WIDTH_DEFAULT;
    localparam int HALF = FRAME_W / 2;
    localparam int PHASE_BYTES = 150;
    localparam int NUM_PHASES = 6;
    localparam int SQUEEZE_PHASE = 3;
    localparam int SQUEEZE_CYCLES = 400;
    localparam int MAX_GAP = 13;

    // Scoreboard: keeps its own copy of the block state and the expected results.
    class steer_scoreboard;
        cfg_t regs;
        int unsigned fill;
        logic [7:0] head [HEAD_BYTES];
        steer_code_t last_code;
        logic [15:0] last_cx;
        out_item_t awaited [$];
        int unsigned errors;

        function new();
            regs = {CENTER_MARGIN_RESET, NEAR_AREA_RESET, MIN_AREA_RESET, MAX_AREA_RESET};
            fill = 0;
            last_code = STEER_SEEK_LEFT;
            last_cx = '0;
            errors = 0;
        endfunction

        function void set_register(logic [7:0] idx, logic [23:0] data);
            case (idx)
                REG_CENTER_MARGIN: regs.center_margin = data[7:0];
                REG_NEAR_AREA:     regs.near_area = data;
                REG_MIN_AREA:      regs.min_area = data;
                REG_MAX_AREA:      regs.max_area = data;
                default: ;
            endcase
        endfunction

        function int pending();
            return awaited.size();
        endfunction

        function steer_code_t seek_direction();
            int p;
            bit seeking;
            p = int'(last_cx);
            seeking = (last_code == STEER_SEEK_LEFT) || (last_code == STEER_SEEK_RIGHT);
            if (!seeking && p > HALF && p <= FRAME_W)
                return STEER_SEEK_RIGHT;
            if (!seeking && p < HALF && p > 0)
                return STEER_SEEK_LEFT;
            if (seeking)
                return last_code;
            return STEER_SEEK;
        endfunction

        function steer_code_t classify(logic [15:0] cx_bits, logic [23:0] area);
            int cx;
            int margin;
            int lo;
            int hi;
            cx = int'(cx_bits);
            margin = int'(regs.center_margin);
            // The band bounds are signed and go negative for wide margins.
            lo = HALF - margin;
            hi = HALF + margin;
            if (!(cx > 0 && cx < FRAME_W && area > regs.min_area && area < regs.max_area))
                return seek_direction();
            if (area > regs.near_area)
                return STEER_STOP;
            if (cx > lo && cx < hi)
                return STEER_STRAIGHT;
            if (cx <= lo - ROTATE_EXTRA)
                return STEER_ROTATE_LEFT;
            if (cx >= hi + ROTATE_EXTRA)
                return STEER_ROTATE_RIGHT;
            if (cx <= lo)
                return STEER_LEFT;
            return STEER_RIGHT;
        endfunction

        function void note_byte(in_item_t it);
            out_item_t r;
            steer_code_t code;
            if (it.report_start)
                fill = 0;
            if (fill < HEAD_BYTES)
            begin
                head[fill] = it.data_byte;
                fill++;
                return;
            end
            fill = 0;
            r.blob_x = {head[0], head[1]};
            r.blob_y = {head[2], head[3]};
            r.blob_w = {head[4], head[5]};
            r.blob_h = {head[6], head[7]};
            r.blob_cx = {head[8], head[9]};
            r.blob_cy = {head[10], head[11]};
            r.blob_area = {head[12], head[13], it.data_byte};
            code = classify(r.blob_cx, r.blob_area);
            r.steer_code = code;
            last_code = code;
            last_cx = r.blob_cx;
            awaited.push_back(r);
        endfunction

        function void compare(string what, logic [23:0] want, logic [23:0] got);
            if (got !== want)
            begin
                $display("%0t: %s expected %0d, got %0d", $time, what, want, got);
                errors++;
            end
        endfunction

        function void check_result(out_item_t got);
            out_item_t want;
            if (awaited.size() == 0)
            begin
                $display("%0t: result expected none, got %h", $time, got);
                errors++;
                return;
            end
            want = awaited.pop_front();
            compare("steer_code", 24'(want.steer_code), 24'(got.steer_code));
            compare("blob_x", 24'(want.blob_x), 24'(got.blob_x));
            compare("blob_y", 24'(want.blob_y), 24'(got.blob_y));
            compare("blob_w", 24'(want.blob_w), 24'(got.blob_w));
            compare("blob_h", 24'(want.blob_h), 24'(got.blob_h));
            compare("blob_cx", 24'(want.blob_cx), 24'(got.blob_cx));
            compare("blob_cy", 24'(want.blob_cy), 24'(got.blob_cy));
            compare("blob_area", want.blob_area, got.blob_area);
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic item_valid = 1'b0;
    logic item_ready;
    in_item_t item = '0;
    logic result_valid;
    logic result_ready = 1'b0;
    out_item_t result;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [7:0] cfg_index = '0;
    logic [23:0] cfg_data = '0;

    steer_scoreboard sb;
    int unsigned bytes_sent = 0;
    int unsigned quiet_items = 0;
    bit send_busy = 1'b0;
    bit recv_busy = 1'b0;
    bit squeeze_req = 1'b0;

    always #2 clk = ~clk;

    vision_target_steering_classifier #(
        .FRAME_WIDTH(FRAME_W)
    ) u_top (
        .clk(clk),
        .rst_n(rst_n),
        .item_valid(item_valid),
        .item_ready(item_ready),
        .item(item),
        .result_valid(result_valid),
        .result_ready(result_ready),
        .result(result),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    // Every transfer on the three channels goes to the scoreboard.
    always @(posedge clk)
    begin
        if (item_valid && item_ready)
            sb.note_byte(item);
        if (result_valid && result_ready)
            sb.check_result(result);
        if (cfg_valid && cfg_ready)
            sb.set_register(cfg_index, cfg_data);
    end

    function automatic int sender_gap();
        if (quiet_items > 0)
        begin
            quiet_items--;
            return 0;
        end
        if ($urandom_range(0, 39) == 0)
            send_busy = !send_busy;
        return send_busy ? int'($urandom_range(0, MAX_GAP)) : 0;
    endfunction

    function automatic int receiver_gap();
        if ($urandom_range(0, 5) == 0)
            recv_busy = !recv_busy;
        return recv_busy ? int'($urandom_range(0, MAX_GAP)) : 0;
    endfunction

    function automatic int clamp(int v, int top);
        if (v < 0)
            return 0;
        if (v > top)
            return top;
        return v;
    endfunction

    function automatic logic [23:0] in_band_area();
        if (sb.regs.max_area > sb.regs.min_area + 1)
            return 24'($urandom_range(sb.regs.min_area + 1, sb.regs.max_area - 1));
        return 24'($urandom_range(0, 24'hFFFFFF));
    endfunction

    function automatic logic [15:0] pick_cx();
        int lo;
        int hi;
        int v;
        int sel;
        lo = HALF - int'(sb.regs.center_margin);
        hi = HALF + int'(sb.regs.center_margin);
        sel = $urandom_range(0, 99);
        if (sel < 45)
            v = $urandom_range(1, FRAME_W - 1);
        else if (sel < 75)
        begin
            case ($urandom_range(0, 11))
                0: v = lo;
                1: v = lo + 1;
                2: v = lo - 1;
                3: v = hi;
                4: v = hi - 1;
                5: v = hi + 1;
                6: v = lo - ROTATE_EXTRA;
                7: v = lo - ROTATE_EXTRA + 1;
                8: v = hi + ROTATE_EXTRA;
                9: v = hi + ROTATE_EXTRA - 1;
                10: v = HALF;
                default: v = HALF + 1;
            endcase
        end
        else if (sel < 85)
            v = $urandom_range(0, 16'hFFFF);
        else
        begin
            case ($urandom_range(0, 4))
                0: v = 0;
                1: v = 1;
                2: v = FRAME_W - 1;
                3: v = FRAME_W;
                default: v = 16'hFFFF;
            endcase
        end
        return 16'(clamp(v, 16'hFFFF));
    endfunction

    function automatic logic [23:0] pick_area();
        int mn;
        int mx;
        int nr;
        int v;
        int sel;
        mn = int'(sb.regs.min_area);
        mx = int'(sb.regs.max_area);
        nr = int'(sb.regs.near_area);
        sel = $urandom_range(0, 99);
        if (sel < 55)
            return in_band_area();
        if (sel < 75)
        begin
            case ($urandom_range(0, 5))
                0: v = mn;
                1: v = mn + 1;
                2: v = mx - 1;
                3: v = mx;
                4: v = nr;
                default: v = nr + 1;
            endcase
            return 24'(clamp(v, 24'hFFFFFF));
        end
        if (sel < 90)
            return 24'($urandom_range(0, 24'hFFFFFF));
        return $urandom_range(0, 1) ? 24'hFFFFFF : 24'h0;
    endfunction

    function automatic logic [15:0] pick_word();
        if ($urandom_range(0, 4) == 0)
            return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
        return 16'($urandom_range(0, 16'hFFFF));
    endfunction

    function automatic report_t make_report();
        report_t rep;
        rep.blob_x = pick_word();
        rep.blob_y = pick_word();
        rep.blob_w = pick_word();
        rep.blob_h = pick_word();
        rep.blob_cx = pick_cx();
        rep.blob_cy = pick_word();
        rep.blob_area = pick_area();
        return rep;
    endfunction

    task automatic send_byte(input logic [7:0] data, input logic start);
        int gap;
        gap = sender_gap();
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_valid <= 1'b1;
        item <= {data, start};
        @(posedge clk);
        while (!item_ready) @(posedge clk);
        bytes_sent++;
    endtask

    // Bytes go out most significant first, which is the packed field order.
    task automatic send_report(input report_t rep, input bit mark);
        for (int i = 0; i < REPORT_BYTES; i++)
            send_byte(rep[8 * (REPORT_BYTES - i) - 1 -: 8], mark && i == 0);
    endtask

    task automatic write_reg(input logic [7:0] idx, input logic [23:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
    endtask

    // Waits until every expected result is back and the pipeline has drained.
    task automatic settle();
        item_valid <= 1'b0;
        do @(posedge clk); while (sb.pending() != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic load_phase_config(input int ph);
        int mn;
        int mx;
        case (ph)
            1:
            begin
                write_reg(REG_CENTER_MARGIN, 24'd0);
                write_reg(REG_NEAR_AREA, 24'hFFFFFF);
                write_reg(REG_MIN_AREA, 24'd0);
                write_reg(REG_MAX_AREA, 24'hFFFFFF);
                // Indexes past the last register must be ignored.
                write_reg(8'($urandom_range(REG_MAX_AREA + 1, 255)),
                          24'($urandom_range(0, 24'hFFFFFF)));
            end
            2:
            begin
                write_reg(REG_CENTER_MARGIN, 24'd159);
                write_reg(REG_NEAR_AREA, 24'hFFFFFF);
                write_reg(REG_MIN_AREA, 24'd0);
                write_reg(REG_MAX_AREA, 24'hFFFFFF);
            end
            4:
            begin
                write_reg(REG_CENTER_MARGIN, 24'($urandom_range(0, 159)));
                write_reg(REG_NEAR_AREA, 24'd0);
                write_reg(REG_MIN_AREA, 24'hFFFFFF);
                write_reg(REG_MAX_AREA, 24'd0);
            end
            default:
            begin
                mn = $urandom_range(0, 5000);
                mx = mn + $urandom_range(2, 200000);
                write_reg(REG_CENTER_MARGIN, 24'($urandom_range(0, 159)));
                write_reg(REG_MIN_AREA, 24'(mn));
                write_reg(REG_MAX_AREA, 24'(mx));
                write_reg(REG_NEAR_AREA, 24'($urandom_range(mn, mx)));
            end
        endcase
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    initial
    begin : receiver
        int gap;
        wait (rst_n);
        forever
        begin
            if (squeeze_req)
            begin
                squeeze_req = 1'b0;
                gap = SQUEEZE_CYCLES;
            end
            else
                gap = receiver_gap();
            if (gap > 0)
            begin
                result_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            result_ready <= 1'b1;
            @(posedge clk);
            while (!result_valid) @(posedge clk);
        end
    end

    initial
    begin : timeout
        #2_000_000;
        $display("vision_target_steering_classifier_tb: done, errors");
        $finish;
    end

    initial
    begin : stimulus
        report_t rep;
        int unsigned phase_end;
        int roll;
        int n;
        sb = new();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // A report cut short by a new start mark, then a report of all ones.
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_report({8 * REPORT_BYTES{1'b1}}, 1'b1);
        settle();

        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            if (ph > 0)
                load_phase_config(ph);
            if (ph == SQUEEZE_PHASE)
            begin
                // Long receiver stall with a back-to-back sender fills the block.
                squeeze_req = 1'b1;
                quiet_items = 250;
            end
            phase_end = bytes_sent + PHASE_BYTES;
            while (bytes_sent < phase_end)
            begin
                rep = make_report();
                roll = $urandom_range(0, 99);
                if (roll < 8)
                begin
                    // A blob dead on centre, valid where the area limits allow, then a lost blob gives plain seek.
                    rep.blob_cx = 16'(HALF);
                    rep.blob_area = in_band_area();
                    send_report(rep, 1'b1);
                    rep = make_report();
                    rep.blob_cx = 16'd0;
                    send_report(rep, 1'b1);
                end
                else if (roll < 18)
                begin
                    n = $urandom_range(1, HEAD_BYTES);
                    for (int k = 0; k < n; k++)
                        send_byte(8'($urandom_range(0, 255)),
                                  k == 0 ? 1'($urandom_range(0, 1))
                                         : ($urandom_range(0, 9) == 0));
                    send_report(rep, 1'b1);
                end
                else
                    send_report(rep, $urandom_range(0, 3) != 0);
            end
            settle();
        end

        repeat (8) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("vision_target_steering_classifier_tb: done, clean");
        else
            $display("vision_target_steering_classifier_tb: done, errors");
        $finish;
    end

endmodule

// ===== files.f =====
hdl/vtsc_pkg.sv
hdl/vtsc_front.sv
hdl/vtsc_queue.sv
hdl/vtsc_back.sv
hdl/vision_target_steering_classifier.sv
hdl/vtsc_checker.sv
sim/vision_target_steering_classifier_tb.sv
